// ----- rtl/apu_pkg.sv -----
package apu_pkg;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;

  localparam logic [31:0] BETA_ONE_RST  = 32'h3F66_6666;
  localparam logic [31:0] BETA_TWO_RST  = 32'h3F7F_BE77;
  localparam logic [31:0] EPSILON_RST   = 32'h322B_CC77;
  localparam logic [31:0] STEP_SIZE_RST = 32'h38D1_B717;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA_ONE    = 3'd0,
    REG_BETA_TWO    = 3'd1,
    REG_EPSILON     = 3'd2,
    REG_STEP_SIZE   = 3'd3,
    REG_GRAD_FORMAT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] gradient;
    logic [31:0] moment_one;
    logic [31:0] moment_two;
    logic [31:0] param_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_moment_one;
    logic [31:0] new_moment_two;
    logic [31:0] new_param_value;
  } out_item_t;

  typedef struct packed {
    logic        sign;
    logic [9:0]  expo;
    logic [23:0] mant;
    logic        zero;
    logic        inf;
    logic        nan;
  } fp_unp_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [11:0] e;
    logic [47:0]        prod;
  } mul_mid_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic        sub;
    logic        zsign;
    logic [9:0]  e;
    logic [26:0] siga;
    logic [26:0] sigb;
  } add_mid_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic [7:0]  rexp;
    logic [47:0] n;
  } sq_pre_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [11:0] e;
    logic [23:0]        ma;
    logic [23:0]        mb;
  } dv_pre_t;

  function automatic fp_unp_t fp_unpack(input logic [31:0] a);
    fp_unp_t u;
    u.sign = a[31];
    if (a[30:23] == 8'd0) begin
      u.expo = 10'd1;
      u.mant = {1'b0, a[22:0]};
    end else begin
      u.expo = {2'b0, a[30:23]};
      u.mant = {1'b1, a[22:0]};
    end
    u.zero = (a[30:0] == 31'd0);
    u.inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    u.nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    return u;
  endfunction

  // leading zero count, input must be nonzero
  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [26:0] shr_sticky(input logic [26:0] x, input logic [4:0] amt);
    logic [26:0] msk;
    msk = ~(27'h7FF_FFFF << amt);
    return (x >> amt) | 27'(|(x & msk));
  endfunction

  // value = sig/2^26 * 2^(e-127); sig[26] set; sig[1:0] sticky
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
                                           input logic [26:0] sig);
    logic [26:0] s;
    logic [11:0] eb;
    logic [4:0]  amt;
    logic        inc;
    logic [24:0] m;
    logic [35:0] tot;
    if (e <= 12'sd0) begin
      amt = (e < -12'sd25) ? 5'd27 : 5'(12'sd1 - e);
      s   = shr_sticky(sig, amt);
      eb  = 12'd0;
    end else begin
      amt = 5'd0;
      s   = sig;
      eb  = 12'(e - 12'sd1);
    end
    inc = s[2] & (s[3] | (|s[1:0]));
    m   = {1'b0, s[26:3]} + 25'(inc);
    tot = {1'b0, eb, 23'd0} + {11'd0, m};
    if (tot >= (36'd255 << 23)) begin
      return {sign, 8'hFF, 23'd0};
    end
    return {sign, tot[30:0]};
  endfunction

  function automatic mul_mid_t mul_pre(input logic [31:0] a, input logic [31:0] b);
    fp_unp_t  ua;
    fp_unp_t  ub;
    mul_mid_t r;
    ua = fp_unpack(a);
    ub = fp_unpack(b);
    r.sign = a[31] ^ b[31];
    r.spec = 1'b1;
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      r.spec_val = QNAN;
    end else if (ua.inf || ub.inf) begin
      r.spec_val = {r.sign, 8'hFF, 23'd0};
    end else if (ua.zero || ub.zero) begin
      r.spec_val = {r.sign, 31'd0};
    end else begin
      r.spec     = 1'b0;
      r.spec_val = QNAN;
    end
    r.prod = ua.mant * ub.mant;
    r.e    = $signed({2'b0, ua.expo}) + $signed({2'b0, ub.expo}) - 12'sd126;
    return r;
  endfunction

  function automatic logic [31:0] mul_post(input mul_mid_t mid);
    logic [5:0]  lz;
    logic [47:0] pn;
    lz = lzc48(mid.prod);
    pn = mid.prod << lz;
    if (mid.spec) return mid.spec_val;
    return fp_round(mid.sign, mid.e - $signed({6'b0, lz}), {pn[47:22], |pn[21:0]});
  endfunction

  function automatic add_mid_t add_pre(input logic [31:0] a, input logic [31:0] b);
    fp_unp_t  ua;
    fp_unp_t  ub;
    fp_unp_t  big;
    fp_unp_t  sml;
    logic [9:0] d;
    add_mid_t r;
    ua = fp_unpack(a);
    ub = fp_unpack(b);
    r.spec = 1'b1;
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) begin
      r.spec_val = QNAN;
    end else if (ua.inf) begin
      r.spec_val = a;
    end else if (ub.inf) begin
      r.spec_val = b;
    end else begin
      r.spec     = 1'b0;
      r.spec_val = QNAN;
    end
    if ({ub.expo, ub.mant} > {ua.expo, ua.mant}) begin
      big = ub;
      sml = ua;
    end else begin
      big = ua;
      sml = ub;
    end
    d       = big.expo - sml.expo;
    r.sign  = big.sign;
    r.sub   = ua.sign ^ ub.sign;
    r.zsign = ua.sign & ub.sign;
    r.e     = big.expo;
    r.siga  = {big.mant, 3'd0};
    r.sigb  = shr_sticky({sml.mant, 3'd0}, (d > 10'd27) ? 5'd27 : d[4:0]);
    return r;
  endfunction

  function automatic logic [31:0] add_post(input add_mid_t mid);
    logic [27:0] dsum;
    logic [5:0]  lz;
    logic [27:0] dn;
    dsum = mid.sub ? ({1'b0, mid.siga} - {1'b0, mid.sigb})
                   : ({1'b0, mid.siga} + {1'b0, mid.sigb});
    lz = lzc48({dsum, 20'd0});
    dn = dsum << lz;
    if (mid.spec) return mid.spec_val;
    if (dsum == 28'd0) return {mid.zsign, 31'd0};
    return fp_round(mid.sign, $signed({2'b0, mid.e}) + 12'sd1 - $signed({6'b0, lz}),
                    {dn[27:2], dn[1] | dn[0]});
  endfunction

  function automatic sq_pre_t sqrt_pre(input logic [31:0] a);
    fp_unp_t            u;
    logic [5:0]         lz;
    logic [23:0]        m;
    logic signed [11:0] x;
    logic signed [11:0] xe;
    logic [24:0]        mm;
    sq_pre_t            r;
    u  = fp_unpack(a);
    lz = lzc48({u.mant, 24'd0});
    m  = u.mant << lz;
    x  = $signed({2'b0, u.expo}) - 12'sd127 - $signed({6'b0, lz});
    xe = x[0] ? (x - 12'sd1) : x;
    mm = x[0] ? {m, 1'b0} : {1'b0, m};
    r.spec = 1'b1;
    if (u.nan || (u.sign && !u.zero)) begin
      r.spec_val = QNAN;
    end else if (u.zero || u.inf) begin
      r.spec_val = a;
    end else begin
      r.spec     = 1'b0;
      r.spec_val = QNAN;
    end
    r.rexp = 8'((xe >>> 1) + 12'sd127);
    r.n    = {mm, 23'd0};
    return r;
  endfunction

  function automatic dv_pre_t div_pre(input logic [31:0] a, input logic [31:0] b);
    fp_unp_t    ua;
    fp_unp_t    ub;
    logic [5:0] lza;
    logic [5:0] lzb;
    dv_pre_t    r;
    ua  = fp_unpack(a);
    ub  = fp_unpack(b);
    lza = lzc48({ua.mant, 24'd0});
    lzb = lzc48({ub.mant, 24'd0});
    r.sign = a[31] ^ b[31];
    r.spec = 1'b1;
    if (ua.nan || ub.nan || (ua.zero && ub.zero) || (ua.inf && ub.inf)) begin
      r.spec_val = QNAN;
    end else if (ua.inf || ub.zero) begin
      r.spec_val = {r.sign, 8'hFF, 23'd0};
    end else if (ua.zero || ub.inf) begin
      r.spec_val = {r.sign, 31'd0};
    end else begin
      r.spec     = 1'b0;
      r.spec_val = QNAN;
    end
    r.ma = ua.mant << lza;
    r.mb = ub.mant << lzb;
    r.e  = $signed({2'b0, ua.expo}) - $signed({6'b0, lza}) - $signed({2'b0, ub.expo})
         + $signed({6'b0, lzb}) + 12'sd127;
    return r;
  endfunction

  // quo = floor(ma * 2^26 / mb), rem nonzero means inexact
  function automatic logic [31:0] div_post(input dv_pre_t p, input logic [26:0] quo,
                                           input logic [24:0] rem);
    logic st;
    st = |rem;
    if (p.spec) return p.spec_val;
    if (quo[26]) return fp_round(p.sign, p.e, {quo[26:1], quo[0] | st});
    return fp_round(p.sign, p.e - 12'sd1, {quo[25:0], st});
  endfunction

endpackage

// ----- rtl/adam_parameter_update.sv -----
// Adam parameter update, IEEE single precision, round to nearest even.
// One item per cycle sustained, except while the output skid buffer holds a refused result.
// The depth is set by the square root (24 stages, one root bit each) and the
// divider (27 stages, one quotient bit each) plus two-stage multiply/add units.
// Reset (synchronous, active high) empties the pipeline and output buffer and
// loads the default beta_one, beta_two, epsilon, step_size and fp32 gradients.
module adam_parameter_update (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  apu_pkg::in_item_t                item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output apu_pkg::out_item_t               result,
  input  logic                             wr_en,
  input  logic [apu_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [31:0]                      wr_data
);

  localparam int SqSteps   = 24;
  localparam int DvSteps   = 27;
  // 4 mul/add levels, sqrt (pre+steps+post), eps add, div (pre+steps+post), final add
  localparam int NumStages = 8 + SqSteps + 2 + 2 + DvSteps + 2 + 2;

  typedef struct packed {
    logic [31:0] mn;
    logic [31:0] vn;
    logic [31:0] num;
    logic [31:0] w;
  } sq_carry_t;

  typedef struct packed {
    logic [31:0] mn;
    logic [31:0] vn;
    logic [31:0] w;
  } dv_carry_t;

  // configuration registers
  logic [31:0] beta_one;
  logic [31:0] beta_two;
  logic [31:0] epsilon;
  logic [31:0] step_size;
  logic        grad_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_one    <= apu_pkg::BETA_ONE_RST;
      beta_two    <= apu_pkg::BETA_TWO_RST;
      epsilon     <= apu_pkg::EPSILON_RST;
      step_size   <= apu_pkg::STEP_SIZE_RST;
      grad_format <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        apu_pkg::REG_BETA_ONE:    beta_one    <= wr_data;
        apu_pkg::REG_BETA_TWO:    beta_two    <= wr_data;
        apu_pkg::REG_EPSILON:     epsilon     <= wr_data;
        apu_pkg::REG_STEP_SIZE:   step_size   <= wr_data;
        apu_pkg::REG_GRAD_FORMAT: grad_format <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Flow control: the whole pipe moves together. The skid buffer behind the
  // last stage catches a result the sink refuses, so the pipe only halts
  // while that buffer is occupied.
  logic                   adv;
  logic [NumStages-1:0]   vld;
  logic                   skid_vld;
  apu_pkg::out_item_t     skid;
  apu_pkg::out_item_t     pipe_out;

  assign adv          = !skid_vld;
  assign item_ready   = adv;
  assign result_valid = skid_vld | vld[NumStages-1];
  assign result       = skid_vld ? skid : pipe_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      skid_vld <= 1'b0;
    end else begin
      if (adv) begin
        vld <= {vld[NumStages-2:0], item_valid};
      end
      if (skid_vld) begin
        if (result_ready) begin
          skid_vld <= 1'b0;
        end
      end else if (vld[NumStages-1] && !result_ready) begin
        skid_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) begin
      skid <= pipe_out;
    end
  end

  // bfloat16 gradients sit in the low half and are widened to fp32
  logic [31:0] g_in;
  assign g_in = grad_format ? {item.gradient[15:0], 16'd0} : item.gradient;

  // Levels 1-4: each op is a two-stage unit (operate, then normalize/round).
  // L1: 1-b1, 1-b2, b1*m, b2*v
  apu_pkg::mul_mid_t s1_t1, s1_u1;
  apu_pkg::add_mid_t s1_om1, s1_om2;
  logic [31:0]       s1_g, s1_w;
  logic [31:0]       s2_t1, s2_u1, s2_om1, s2_om2, s2_g, s2_w;
  // L2: (1-b1)*g, (1-b2)*g
  apu_pkg::mul_mid_t s3_t2, s3_g2;
  logic [31:0]       s3_t1, s3_u1, s3_g, s3_w;
  logic [31:0]       s4_t2, s4_g2, s4_t1, s4_u1, s4_g, s4_w;
  // L3: mn = t1+t2, ((1-b2)*g)*g
  apu_pkg::add_mid_t s5_mn;
  apu_pkg::mul_mid_t s5_gg;
  logic [31:0]       s5_u1, s5_w;
  logic [31:0]       s6_mn, s6_gg, s6_u1, s6_w;
  // L4: vn = b2*v + g2*g, num = lr*mn
  apu_pkg::add_mid_t s7_vn;
  apu_pkg::mul_mid_t s7_num;
  logic [31:0]       s7_mn, s7_w;
  logic [31:0]       s8_vn, s8_num, s8_mn, s8_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t1  <= apu_pkg::mul_pre(beta_one, item.moment_one);
      s1_u1  <= apu_pkg::mul_pre(beta_two, item.moment_two);
      s1_om1 <= apu_pkg::add_pre(apu_pkg::FP_ONE, {~beta_one[31], beta_one[30:0]});
      s1_om2 <= apu_pkg::add_pre(apu_pkg::FP_ONE, {~beta_two[31], beta_two[30:0]});
      s1_g   <= g_in;
      s1_w   <= item.param_value;

      s2_t1  <= apu_pkg::mul_post(s1_t1);
      s2_u1  <= apu_pkg::mul_post(s1_u1);
      s2_om1 <= apu_pkg::add_post(s1_om1);
      s2_om2 <= apu_pkg::add_post(s1_om2);
      s2_g   <= s1_g;
      s2_w   <= s1_w;

      s3_t2  <= apu_pkg::mul_pre(s2_om1, s2_g);
      s3_g2  <= apu_pkg::mul_pre(s2_om2, s2_g);
      s3_t1  <= s2_t1;
      s3_u1  <= s2_u1;
      s3_g   <= s2_g;
      s3_w   <= s2_w;

      s4_t2  <= apu_pkg::mul_post(s3_t2);
      s4_g2  <= apu_pkg::mul_post(s3_g2);
      s4_t1  <= s3_t1;
      s4_u1  <= s3_u1;
      s4_g   <= s3_g;
      s4_w   <= s3_w;

      s5_mn  <= apu_pkg::add_pre(s4_t1, s4_t2);
      s5_gg  <= apu_pkg::mul_pre(s4_g2, s4_g);
      s5_u1  <= s4_u1;
      s5_w   <= s4_w;

      s6_mn  <= apu_pkg::add_post(s5_mn);
      s6_gg  <= apu_pkg::mul_post(s5_gg);
      s6_u1  <= s5_u1;
      s6_w   <= s5_w;

      s7_vn  <= apu_pkg::add_pre(s6_u1, s6_gg);
      s7_num <= apu_pkg::mul_pre(step_size, s6_mn);
      s7_mn  <= s6_mn;
      s7_w   <= s6_w;

      s8_vn  <= apu_pkg::add_post(s7_vn);
      s8_num <= apu_pkg::mul_post(s7_num);
      s8_mn  <= s7_mn;
      s8_w   <= s7_w;
    end
  end

  // Square root: restoring digit recurrence, one root bit per stage.
  // Each stage pulls the next two radicand bits into the partial remainder.
  apu_pkg::sq_pre_t sq_pre  [0:SqSteps];
  logic [25:0]      sq_rem  [0:SqSteps];
  logic [23:0]      sq_root [0:SqSteps];
  sq_carry_t        sq_cy   [0:SqSteps];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pre[0]  <= apu_pkg::sqrt_pre(s8_vn);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_cy[0]   <= '{mn: s8_mn, vn: s8_vn, num: s8_num, w: s8_w};
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    logic [27:0] rs;
    logic [27:0] tt;
    logic        ge;
    assign rs = {sq_rem[k], sq_pre[k].n[2*(SqSteps-1-k)+1 -: 2]};
    assign tt = {2'b00, sq_root[k], 2'b01};
    assign ge = (rs >= tt);

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_pre[k+1]  <= sq_pre[k];
        sq_cy[k+1]   <= sq_cy[k];
        sq_rem[k+1]  <= ge ? 26'(rs - tt) : 26'(rs);
        sq_root[k+1] <= {sq_root[k][22:0], ge};
      end
    end
  end

  // round: the remainder exceeds the root exactly when the true root lies
  // above the halfway point (a tie cannot happen)
  logic [24:0] sq_rnd;
  logic [31:0] sq_res;
  assign sq_rnd = {1'b0, sq_root[SqSteps]}
                + 25'(sq_rem[SqSteps] > {2'b00, sq_root[SqSteps]});
  assign sq_res = sq_pre[SqSteps].spec ? sq_pre[SqSteps].spec_val
                : ({1'b0, sq_pre[SqSteps].rexp, 23'd0} + {7'd0, sq_rnd} - 32'h0080_0000);

  logic [31:0]       s9_s;
  sq_carry_t         s9_cy;
  apu_pkg::add_mid_t s10_den;
  sq_carry_t         s10_cy;
  logic [31:0]       s11_den;
  sq_carry_t         s11_cy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_s    <= sq_res;
      s9_cy   <= sq_cy[SqSteps];
      s10_den <= apu_pkg::add_pre(s9_s, epsilon);
      s10_cy  <= s9_cy;
      s11_den <= apu_pkg::add_post(s10_den);
      s11_cy  <= s10_cy;
    end
  end

  // Divider: restoring, one quotient bit per stage, 27 bits cover the
  // mantissa, guard and round positions; the final remainder gives sticky.
  apu_pkg::dv_pre_t dv_pre [0:DvSteps];
  logic [24:0]      dv_rem [0:DvSteps];
  logic [26:0]      dv_quo [0:DvSteps];
  dv_carry_t        dv_cy  [0:DvSteps];
  apu_pkg::dv_pre_t dv_first;

  assign dv_first = apu_pkg::div_pre(s11_cy.num, s11_den);

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_pre[0] <= dv_first;
      dv_rem[0] <= {1'b0, dv_first.ma};
      dv_quo[0] <= '0;
      dv_cy[0]  <= '{mn: s11_cy.mn, vn: s11_cy.vn, w: s11_cy.w};
    end
  end

  for (genvar k = 0; k < DvSteps; k++) begin : g_dv
    logic        ge;
    logic [24:0] dif;
    assign ge  = (dv_rem[k] >= {1'b0, dv_pre[k].mb});
    assign dif = ge ? (dv_rem[k] - {1'b0, dv_pre[k].mb}) : dv_rem[k];

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_pre[k+1] <= dv_pre[k];
        dv_cy[k+1]  <= dv_cy[k];
        dv_rem[k+1] <= {dif[23:0], 1'b0};
        dv_quo[k+1] <= {dv_quo[k][25:0], ge};
      end
    end
  end

  // quotient rounding, then w + q
  logic [31:0]       s12_q;
  dv_carry_t         s12_cy;
  apu_pkg::add_mid_t s13_wn;
  logic [31:0]       s13_mn, s13_vn;
  logic [31:0]       s14_wn, s14_mn, s14_vn;

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_q  <= apu_pkg::div_post(dv_pre[DvSteps], dv_quo[DvSteps], dv_rem[DvSteps]);
      s12_cy <= dv_cy[DvSteps];
      s13_wn <= apu_pkg::add_pre(s12_cy.w, s12_q);
      s13_mn <= s12_cy.mn;
      s13_vn <= s12_cy.vn;
      s14_wn <= apu_pkg::add_post(s13_wn);
      s14_mn <= s13_mn;
      s14_vn <= s13_vn;
    end
  end

  assign pipe_out = '{new_moment_one: s14_mn, new_moment_two: s14_vn,
                      new_param_value: s14_wn};

endmodule

// ----- verif/adam_parameter_update_tb.sv -----
module adam_parameter_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;     // a little over the pipeline depth
  localparam int HOLDOFF_CYCLES = 300;  // long receiver stall, well past pipeline depth
  localparam int ITEMS_PER_PHASE = 205;
  localparam int NUM_PHASES = 6;

  logic                si_clk_unused_guard;
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  apu_pkg::in_item_t   item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  apu_pkg::out_item_t  result;
  logic                wr_en = 1'b0;
  logic [apu_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [31:0]         wr_data = '0;

  // Mirror of the block's configuration, used by the update predictor.
  logic [31:0] cfg_beta_one = apu_pkg::BETA_ONE_RST;
  logic [31:0] cfg_beta_two = apu_pkg::BETA_TWO_RST;
  logic [31:0] cfg_epsilon = apu_pkg::EPSILON_RST;
  logic [31:0] cfg_step = apu_pkg::STEP_SIZE_RST;
  logic        cfg_bf16 = 1'b0;

  // Directed rows may carry a hand-written expectation alongside the item.
  logic                cur_typed = 1'b0;
  apu_pkg::out_item_t  cur_want = '0;

  apu_pkg::out_item_t pending_updates[$];
  int errors = 0;
  int accepted = 0;
  int retired = 0;
  int nan_results = 0;
  bit holdoff_done = 1'b0;
  bit stimulus_done = 1'b0;

  assign si_clk_unused_guard = clk;

  adam_parameter_update uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fp32 arithmetic by way of double precision. Double carries more than twice
  // the fp32 significand, so one double op followed by a single rounding to
  // fp32 gives the correctly rounded fp32 result for mul, add, div and sqrt.
  // ---------------------------------------------------------------------------
  function automatic real f32_to_real(logic [31:0] a);
    real r;
    if (a[30:23] == 8'd0) begin
      if (a[22:0] == 23'd0) return $bitstoreal({a[31], 63'd0});
      // subnormal: frac * 2^-149, exact in double
      r = real'(int'(a[22:0])) * $bitstoreal({1'b0, 11'd874, 52'd0});
      return a[31] ? -r : r;
    end
    if (a[30:23] == 8'hFF) return $bitstoreal({a[31], 11'h7FF, a[22:0], 29'd0});
    return $bitstoreal({a[31], 11'({3'd0, a[30:23]} + 11'd896), a[22:0], 29'd0});
  endfunction

  // round a double to fp32, nearest even, subnormals kept
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] lost;
    logic [63:0] half;
    longint      tot;
    int          ex;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? apu_pkg::QNAN : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    ex = int'(d[62:52]) - 1023;
    if (ex > 128) return {d[63], 8'hFF, 23'd0};
    mag = {11'd0, 1'b1, d[51:0]};
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 54) sh = 54;
    q = mag >> sh;
    lost = mag & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (lost > half || (lost == half && q[0])) q = q + 64'd1;
    // normal: biased exponent minus one, plus q which holds the hidden bit
    tot = (ex >= -126) ? ((longint'(ex + 126) << 23) + longint'(q)) : longint'(q);
    if (tot >= (longint'(255) << 23)) return {d[63], 8'hFF, 23'd0};
    return {d[63], tot[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  function automatic logic [31:0] fp_div(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) / f32_to_real(b));
  endfunction

  function automatic logic [31:0] fp_sqrt(logic [31:0] a);
    if (a[30:23] == 8'hFF && a[22:0] != 23'd0) return apu_pkg::QNAN;
    if (a[30:0] == 31'd0) return a;                    // keeps -0
    if (a[31]) return apu_pkg::QNAN;                   // negative, -inf too
    if (a[30:23] == 8'hFF) return a;
    return real_to_f32($sqrt(f32_to_real(a)));
  endfunction

  function automatic logic [31:0] quiet(logic [31:0] a);
    return (a[30:0] > 31'h7F80_0000) ? apu_pkg::QNAN : a;
  endfunction

  // One Adam step, every intermediate rounded to fp32 in the block's order.
  function automatic apu_pkg::out_item_t adam_expected(apu_pkg::in_item_t it);
    logic [31:0]        g;
    logic [31:0]        mn;
    logic [31:0]        vn;
    logic [31:0]        den;
    apu_pkg::out_item_t o;
    g  = cfg_bf16 ? {it.gradient[15:0], 16'd0} : it.gradient;
    mn = fp_add(fp_mul(cfg_beta_one, it.moment_one),
                fp_mul(fp_add(apu_pkg::FP_ONE, cfg_beta_one ^ 32'h8000_0000), g));
    vn = fp_add(fp_mul(cfg_beta_two, it.moment_two),
                fp_mul(fp_mul(fp_add(apu_pkg::FP_ONE, cfg_beta_two ^ 32'h8000_0000), g), g));
    den = fp_add(fp_sqrt(vn), cfg_epsilon);
    o.new_moment_one  = quiet(mn);
    o.new_moment_two  = quiet(vn);
    o.new_param_value = quiet(fp_add(it.param_value, fp_div(fp_mul(cfg_step, mn), den)));
    return o;
  endfunction

  // Mostly plausible training values, with specials and raw bit noise mixed in.
  function automatic logic [31:0] rand_f32(bit positive);
    logic [31:0] v;
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) begin
      case ($urandom_range(0, 7))
        0: v = 32'h0000_0000;
        1: v = 32'h7F80_0000;
        2: v = 32'h7F80_0000 | 32'($urandom_range(1, 32'h7F_FFFF));
        3: v = 32'($urandom_range(1, 32'h7F_FFFF));
        4: v = 32'h7F7F_FFFF;
        5: v = 32'h0080_0000;
        6: v = 32'h0000_0001;
        default: v = $urandom;
      endcase
      v[31] = positive ? 1'b0 : v[31] ^ 1'($urandom_range(0, 1));
    end else if (k < 80) begin
      v = {1'($urandom_range(0, 1)), 8'($urandom_range(97, 137)), 23'($urandom)};
      if (positive) v[31] = 1'b0;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic report_err(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: sample at the rising edge, before the block's own updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) begin
      pending_updates.push_back(cur_typed ? cur_want : adam_expected(item));
      accepted++;
    end
  end

  always @(posedge clk) begin
    apu_pkg::out_item_t want;
    if (!rst && result_valid && result_ready) begin
      retired++;
      if (result.new_param_value == apu_pkg::QNAN) nan_results++;
      if (pending_updates.size() == 0) begin
        report_err($sformatf("result with nothing outstanding: %h", result));
      end else begin
        want = pending_updates.pop_front();
        if (result.new_moment_one !== want.new_moment_one)
          report_err($sformatf("#%0d new_moment_one got %h want %h", retired,
                               result.new_moment_one, want.new_moment_one));
        if (result.new_moment_two !== want.new_moment_two)
          report_err($sformatf("#%0d new_moment_two got %h want %h", retired,
                               result.new_moment_two, want.new_moment_two));
        if (result.new_param_value !== want.new_param_value)
          report_err($sformatf("#%0d new_param_value got %h want %h", retired,
                               result.new_param_value, want.new_param_value));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between always-ready, random and periodic stall modes.
  // Once, after the pipe has warmed up, it refuses results for a long stretch
  // while the sender keeps pushing, so backpressure reaches item_ready.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    int phase_cnt;
    mode = 0;
    span = 0;
    phase_cnt = 0;
    @(negedge clk);
    while (!stimulus_done || pending_updates.size() != 0) begin
      @(negedge clk);
      if (!holdoff_done && accepted > 300) begin
        result_ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 200);
      end
      span--;
      phase_cnt++;
      case (mode)
        0: result_ready = 1'b1;
        1: result_ready = ($urandom_range(0, 99) < 60);
        default: result_ready = (phase_cnt % 5) != 0;   // one stall in five
      endcase
    end
    result_ready = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // Present one transaction at the falling edge and hold it until accepted.
  task automatic push_item(input apu_pkg::in_item_t it, input bit typed,
                           input apu_pkg::out_item_t want);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        item_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    item = it;
    cur_typed = typed;
    cur_want = want;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  // Wait for the pipe to empty, then let it settle before touching registers.
  task automatic drain;
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input apu_pkg::cfg_reg_t idx, input logic [31:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      apu_pkg::REG_BETA_ONE:    cfg_beta_one = val;
      apu_pkg::REG_BETA_TWO:    cfg_beta_two = val;
      apu_pkg::REG_EPSILON:     cfg_epsilon = val;
      apu_pkg::REG_STEP_SIZE:   cfg_step = val;
      apu_pkg::REG_GRAD_FORMAT: cfg_bf16 = val[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Typed expectations only where the answer is obvious:
  // zeros, NaN/inf propagation and signed zero handling at reset settings.
  // ---------------------------------------------------------------------------
  typedef struct {
    apu_pkg::in_item_t  stim;
    bit                 typed;
    apu_pkg::out_item_t want;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
    '{{32'h7FC0_0001, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000}, 1'b1,
      {apu_pkg::QNAN, apu_pkg::QNAN, apu_pkg::QNAN}},
    '{{32'h7F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      {32'h7F80_0000, 32'h7F80_0000, apu_pkg::QNAN}},
    '{{32'hFF80_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      {32'hFF80_0000, 32'h7F80_0000, apu_pkg::QNAN}},
    '{{32'h0000_0000, 32'h7F80_0123, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      {apu_pkg::QNAN, 32'h0000_0000, apu_pkg::QNAN}},
    // -0 everywhere: moment stays -0, v' becomes +0, weight stays -0
    '{{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1,
      {32'h8000_0000, 32'h0000_0000, 32'h8000_0000}},
    '{{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF}, 1'b0, '0},
    '{{32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0000, 32'hFF7F_FFFF}, 1'b0, '0},
    '{{32'h0000_0001, 32'h8000_0001, 32'h0000_0001, 32'h0000_0001}, 1'b0, '0},
    '{{32'h007F_FFFF, 32'h0080_0000, 32'h0080_0000, 32'h807F_FFFF}, 1'b0, '0},
    // negative second moment drives sqrt to NaN
    '{{32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000}, 1'b0, '0},
    '{{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{{32'h3A83_126F, 32'h3927_C5AC, 32'h3356_BF95, 32'hBE4C_CCCD}, 1'b0, '0},
    '{{32'hBC23_D70A, 32'hBB03_126F, 32'h3592_1FB5, 32'h3E99_999A}, 1'b0, '0},
    '{{32'h5555_5555, 32'hAAAA_AAAA, 32'h2AAA_AAAA, 32'hD555_5555}, 1'b0, '0},
    '{{32'h4120_0000, 32'h0000_0000, 32'h7F80_0000, 32'h4000_0000}, 1'b0, '0},
    '{{32'h0000_3F80, 32'h3F00_0000, 32'h3E80_0000, 32'h3F80_0000}, 1'b0, '0}
  };

  // Register settings per phase: defaults, sane random, and extremes.
  typedef struct {
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] eps;
    logic [31:0] lr;
    logic        bf16;
  } cfg_set_t;

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_set_t           sets[NUM_PHASES];
    apu_pkg::in_item_t  it;
    apu_pkg::out_item_t none;
    none = '0;

    sets[0] = '{apu_pkg::BETA_ONE_RST, apu_pkg::BETA_TWO_RST, apu_pkg::EPSILON_RST,
                apu_pkg::STEP_SIZE_RST, 1'b0};
    sets[1] = '{{9'h07E, 23'($urandom)}, {9'h07E, 23'($urandom)},
                {1'b0, 8'($urandom_range(90, 110)), 23'($urandom)},
                {1'b0, 8'($urandom_range(110, 125)), 23'($urandom)}, 1'b1};
    // beta zero, beta one, no guard, NaN step size
    sets[2] = '{32'h0000_0000, apu_pkg::FP_ONE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0};
    sets[3] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1};
    sets[4] = '{apu_pkg::FP_ONE, 32'hBF80_0000, 32'h0000_0001, 32'h8000_0001, 1'b0};
    sets[5] = '{apu_pkg::BETA_ONE_RST, apu_pkg::BETA_TWO_RST, apu_pkg::EPSILON_RST,
                apu_pkg::STEP_SIZE_RST, 1'b1};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values in force: directed rows first
    foreach (dir_tab[i]) push_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(apu_pkg::REG_BETA_ONE, sets[ph].b1);
        write_reg(apu_pkg::REG_BETA_TWO, sets[ph].b2);
        write_reg(apu_pkg::REG_EPSILON, sets[ph].eps);
        write_reg(apu_pkg::REG_STEP_SIZE, sets[ph].lr);
        write_reg(apu_pkg::REG_GRAD_FORMAT, {31'd0, sets[ph].bf16});
      end
      gaps_on = (ph != 2);   // one phase streams back to back
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.gradient    = rand_f32(1'b0);
        if (cfg_bf16 && $urandom_range(0, 3) != 0)
          it.gradient[15:0] = it.gradient[31:16] ^ 16'($urandom_range(0, 3));
        it.moment_one  = rand_f32(1'b0);
        it.moment_two  = rand_f32($urandom_range(0, 9) != 0);
        it.param_value = rand_f32(1'b0);
        push_item(it, 1'b0, none);
      end
    end

    item_valid = 1'b0;
    stimulus_done = 1'b1;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_updates.size() != 0)
      report_err($sformatf("%0d updates never returned", pending_updates.size()));

    $display("Ran %0d updates over %0d register settings (fp32/bf16 gradients, specials).",
             accepted, NUM_PHASES);
    $display("Retired %0d results, %0d with NaN weight; receiver hold-off %s.",
             retired, nan_results, holdoff_done ? "exercised" : "not reached");
    if (errors == 0) begin
      $display("adam_parameter_update verification clean");
    end else begin
      $display("adam_parameter_update verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout: %0d accepted, %0d retired", accepted, retired);
    $display("adam_parameter_update verification failed");
    $finish;
  end

endmodule

// ----- adam_parameter_update.f -----
rtl/apu_pkg.sv
rtl/adam_parameter_update.sv
verif/adam_parameter_update_tb.sv
